[rtl/ltteb_pkg.sv]
`default_nettype none

package ltteb_pkg;

    localparam int WINDOW        = 21;
    localparam int WINDOW_OFFSET = WINDOW / 2;
    localparam int SLOT_W        = $clog2(WINDOW);
    localparam int SCAN_BEAMS    = 2048;

    // Depth of the queues between front and back and on the result side.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam int US_PER_S = 1000000;
    localparam int US_PER_MS = 1000;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;

    localparam logic [CFG_INDEX_W-1:0] REG_FORWARD_INDEX = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_MIN     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_MAX     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_NEAR_STOP     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_JUMP_LIMIT    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_SPEED     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_TTC_THRESHOLD = 3'd6;

    localparam logic [1:0] CAUSE_NEAR  = 2'd0;
    localparam logic [1:0] CAUSE_TTC   = 2'd1;
    localparam logic [1:0] CAUSE_CLEAR = 2'd2;

    typedef struct packed {
        logic [10:0] beam_index;
        logic [15:0] range_mm;
        logic        not_a_number;
        logic [31:0] scan_stamp_us;
        logic        last_in_scan;
    } in_t;

    typedef struct packed {
        logic       brake;
        logic [1:0] cause;
        logic [5:0] valid_beams;
    } out_t;

    // Threshold is kept premultiplied to microseconds so the back end needs one product.
    typedef struct packed {
        logic [10:0] forward_index;
        logic [15:0] range_min_mm;
        logic [15:0] range_max_mm;
        logic [15:0] near_stop_mm;
        logic [15:0] jump_limit_mm;
        logic [19:0] max_speed_mm_per_s;
        logic [29:0] ttc_threshold_us;
    } cfg_t;

    // A beam after classification by the front end.
    typedef struct packed {
        logic              in_window;
        logic [SLOT_W-1:0] slot;
        logic [15:0]       range_mm;
        logic              not_a_number;
        logic              last_in_scan;
        logic [31:0]       interval_us;
    } beam_t;

endpackage

`default_nettype wire

[rtl/ltteb_front.sv]
`default_nettype none

module ltteb_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire ltteb_pkg::in_t   in_item,
    input  wire logic [10:0]      forward_index,
    output logic                  q_valid,
    output ltteb_pkg::beam_t      q_head,
    input  wire logic             q_pop
);

    ltteb_pkg::beam_t                  q_slot_reg [ltteb_pkg::QDEPTH];
    logic [ltteb_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [ltteb_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [ltteb_pkg::QPTR_W:0]        count_reg;
    logic [ltteb_pkg::QPTR_W:0]        count_next;

    logic        mid_scan_reg;
    logic        have_stamp_reg;
    logic [31:0] last_stamp_reg;
    logic [31:0] interval_reg;
    logic [31:0] interval_next;

    logic              accept;
    logic signed [12:0] slot_full;
    ltteb_pkg::beam_t  beam;

    assign full    = (count_reg == (ltteb_pkg::QPTR_W + 1)'(ltteb_pkg::QDEPTH));
    assign accept  = push && !full;
    assign q_valid = (count_reg != '0);
    assign q_head  = q_slot_reg[rd_ptr_reg];

    always_comb
    begin
        // The first beam of a scan fixes the interval for the whole scan.
        if (!mid_scan_reg)
        begin
            if (have_stamp_reg && (in_item.scan_stamp_us > last_stamp_reg))
                interval_next = in_item.scan_stamp_us - last_stamp_reg;
            else
                interval_next = '0;
        end
        else
        begin
            interval_next = interval_reg;
        end

        slot_full = $signed({2'b00, in_item.beam_index}) - $signed({2'b00, forward_index})
                    + 13'(ltteb_pkg::WINDOW_OFFSET);

        beam.in_window    = !slot_full[12] && (slot_full < 13'(ltteb_pkg::WINDOW))
                            && (32'(in_item.beam_index) < 32'(ltteb_pkg::SCAN_BEAMS));
        beam.slot         = slot_full[ltteb_pkg::SLOT_W-1:0];
        beam.range_mm     = in_item.range_mm;
        beam.not_a_number = in_item.not_a_number;
        beam.last_in_scan = in_item.last_in_scan;
        beam.interval_us  = interval_next;

        count_next = count_reg;
        if (accept && !q_pop)
            count_next = count_reg + 1'b1;
        else if (!accept && q_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
            mid_scan_reg   <= 1'b0;
            have_stamp_reg <= 1'b0;
            last_stamp_reg <= '0;
            interval_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (q_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (accept)
            begin
                wr_ptr_reg   <= wr_ptr_reg + 1'b1;
                interval_reg <= interval_next;
                if (!mid_scan_reg)
                begin
                    last_stamp_reg <= in_item.scan_stamp_us;
                    have_stamp_reg <= 1'b1;
                end
                mid_scan_reg <= !in_item.last_in_scan;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            q_slot_reg[wr_ptr_reg] <= beam;
    end

endmodule

`default_nettype wire

[rtl/ltteb_back.sv]
`default_nettype none

module ltteb_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ltteb_pkg::cfg_t   cfg,
    input  wire logic              q_valid,
    input  wire ltteb_pkg::beam_t  q_head,
    output logic                   q_pop,
    output logic                   empty,
    input  wire logic              pop,
    output ltteb_pkg::out_t        out_item
);

    // Last range per window beam; zero means no history yet.
    logic [15:0] prev_reg [ltteb_pkg::WINDOW];
    logic        muted_reg;

    // Stage 2: per-beam decision and operands.
    logic        s2_valid_reg;
    logic        s2_near_reg;
    logic        s2_speed_reg;
    logic        s2_last_reg;
    logic        s2_end_reg;
    logic [15:0] s2_diff_reg;
    logic [15:0] s2_range_reg;
    logic [31:0] s2_interval_reg;

    // Stage 3: products for the speed and time-to-collision tests.
    logic        s3_valid_reg;
    logic        s3_near_reg;
    logic        s3_speed_reg;
    logic        s3_last_reg;
    logic        s3_end_reg;
    logic [35:0] s3_spd_lhs_reg;
    logic [51:0] s3_spd_rhs_reg;
    logic [47:0] s3_ttc_lhs_reg;
    logic [45:0] s3_ttc_rhs_reg;

    logic [5:0]  count_reg;
    logic [5:0]  count_next;
    logic        hit_reg;
    logic        hit_next;

    ltteb_pkg::out_t               oq_slot_reg [ltteb_pkg::QDEPTH];
    logic [ltteb_pkg::QPTR_W-1:0]  oq_wr_reg;
    logic [ltteb_pkg::QPTR_W-1:0]  oq_rd_reg;
    logic [ltteb_pkg::QPTR_W:0]    oq_count_reg;
    logic [ltteb_pkg::QPTR_W:0]    oq_count_next;

    logic        adv;
    logic [15:0] prev_cur;
    logic        active;
    logic        near;
    logic        usable;
    logic [15:0] gap;
    logic [15:0] base_mm;
    logic        speed;
    logic        end_cand;
    logic        muted_next;

    logic        s3_fire;
    logic        spd_ok;
    logic [5:0]  count_upd;
    logic        hit_upd;
    logic        emit;
    logic        out_pop;
    ltteb_pkg::out_t emit_item;

    // The back end moves as one block and holds while the result queue is full.
    assign adv     = (oq_count_reg != (ltteb_pkg::QPTR_W + 1)'(ltteb_pkg::QDEPTH));
    assign q_pop   = adv && q_valid;
    assign empty   = (oq_count_reg == '0);
    assign out_pop = pop && !empty;
    assign out_item = oq_slot_reg[oq_rd_reg];

    always_comb
    begin
        if (32'(q_head.slot) < 32'(ltteb_pkg::WINDOW))
            prev_cur = prev_reg[q_head.slot];
        else
            prev_cur = '0;

        active = q_pop && q_head.in_window && !muted_reg;
        near   = active && !q_head.not_a_number && (q_head.range_mm < cfg.near_stop_mm);
        usable = active && !near && !q_head.not_a_number
                 && (q_head.range_mm <= cfg.range_max_mm)
                 && (q_head.range_mm >= cfg.range_min_mm);

        gap     = (prev_cur > q_head.range_mm) ? prev_cur - q_head.range_mm
                                                : q_head.range_mm - prev_cur;
        base_mm = (prev_cur == '0) ? q_head.range_mm : prev_cur;
        speed   = usable && (gap <= cfg.jump_limit_mm) && (q_head.interval_us != '0)
                  && (base_mm > q_head.range_mm);

        end_cand = q_head.last_in_scan && !muted_reg && !near;

        muted_next = muted_reg;
        if (q_pop)
        begin
            if (q_head.last_in_scan)
                muted_next = 1'b0;
            else if (near)
                muted_next = 1'b1;
        end
    end

    always_comb
    begin
        s3_fire   = adv && s3_valid_reg;
        spd_ok    = s3_speed_reg && (52'(s3_spd_lhs_reg) <= s3_spd_rhs_reg);
        count_upd = (spd_ok && (count_reg != 6'h3F)) ? count_reg + 1'b1 : count_reg;
        hit_upd   = hit_reg || (spd_ok && (s3_ttc_lhs_reg < 48'(s3_ttc_rhs_reg)));

        emit_item.brake       = 1'b1;
        emit_item.cause       = ltteb_pkg::CAUSE_NEAR;
        emit_item.valid_beams = count_reg;
        emit = 1'b0;
        if (s3_fire && s3_near_reg)
        begin
            emit = 1'b1;
        end
        else if (s3_fire && s3_end_reg && (count_upd != '0))
        begin
            emit = 1'b1;
            emit_item.brake       = hit_upd;
            emit_item.cause       = hit_upd ? ltteb_pkg::CAUSE_TTC : ltteb_pkg::CAUSE_CLEAR;
            emit_item.valid_beams = count_upd;
        end

        count_next = count_reg;
        hit_next   = hit_reg;
        if (s3_fire)
        begin
            count_next = s3_last_reg ? '0 : count_upd;
            hit_next   = s3_last_reg ? 1'b0 : hit_upd;
        end

        oq_count_next = oq_count_reg;
        if (emit && !out_pop)
            oq_count_next = oq_count_reg + 1'b1;
        else if (!emit && out_pop)
            oq_count_next = oq_count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ltteb_pkg::WINDOW; k++)
                prev_reg[k] <= '0;
            muted_reg    <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            count_reg    <= '0;
            hit_reg      <= 1'b0;
            oq_wr_reg    <= '0;
            oq_rd_reg    <= '0;
            oq_count_reg <= '0;
        end
        else
        begin
            muted_reg    <= muted_next;
            count_reg    <= count_next;
            hit_reg      <= hit_next;
            oq_count_reg <= oq_count_next;
            if (usable)
                prev_reg[q_head.slot] <= q_head.range_mm;
            if (adv)
            begin
                s2_valid_reg <= q_pop;
                s3_valid_reg <= s2_valid_reg;
            end
            if (emit)
                oq_wr_reg <= oq_wr_reg + 1'b1;
            if (out_pop)
                oq_rd_reg <= oq_rd_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_near_reg     <= near;
            s2_speed_reg    <= speed;
            s2_last_reg     <= q_head.last_in_scan;
            s2_end_reg      <= end_cand;
            s2_diff_reg     <= base_mm - q_head.range_mm;
            s2_range_reg    <= q_head.range_mm;
            s2_interval_reg <= q_head.interval_us;

            s3_near_reg    <= s2_near_reg;
            s3_speed_reg   <= s2_speed_reg;
            s3_last_reg    <= s2_last_reg;
            s3_end_reg     <= s2_end_reg;
            s3_spd_lhs_reg <= 36'(s2_diff_reg) * 36'(ltteb_pkg::US_PER_S);
            s3_spd_rhs_reg <= 52'(cfg.max_speed_mm_per_s) * 52'(s2_interval_reg);
            s3_ttc_lhs_reg <= 48'(s2_range_reg) * 48'(s2_interval_reg);
            s3_ttc_rhs_reg <= 46'(cfg.ttc_threshold_us) * 46'(s2_diff_reg);
        end
        if (emit)
            oq_slot_reg[oq_wr_reg] <= emit_item;
    end

endmodule

`default_nettype wire

[rtl/lidar_ttc_emergency_brake.sv]
// Lidar time-to-collision emergency brake. One beam request is taken per clock cycle,
// sustained, for as long as the result queue has room; a result passes the beam queue,
// the history update stage, the registered multiplier stage and the result queue.
// A window beam closer than the stop distance gives an immediate brake result and mutes
// the rest of its scan; otherwise the last beam of a scan gives brake or go, and a scan
// in which no beam passes the speed test gives no result. The user must write registers
// by index only while no request is in flight; the block itself does not enforce this.
`default_nettype none

module lidar_ttc_emergency_brake (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire ltteb_pkg::in_t                      in_item,
    output logic                                     empty,
    input  wire logic                                pop,
    output ltteb_pkg::out_t                          out_item,
    input  wire logic                                cfg_we,
    input  wire logic [ltteb_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [ltteb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam logic [29:0] TTC_RESET_US = 30'(10000 * ltteb_pkg::US_PER_MS);

    ltteb_pkg::cfg_t  cfg_reg;
    logic             q_valid;
    logic             q_pop;
    ltteb_pkg::beam_t q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.forward_index      <= 11'd1024;
            cfg_reg.range_min_mm       <= 16'd0;
            cfg_reg.range_max_mm       <= 16'd65535;
            cfg_reg.near_stop_mm       <= 16'd300;
            cfg_reg.jump_limit_mm      <= 16'd2000;
            cfg_reg.max_speed_mm_per_s <= 20'd10000;
            cfg_reg.ttc_threshold_us   <= TTC_RESET_US;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ltteb_pkg::REG_FORWARD_INDEX: cfg_reg.forward_index <= cfg_data[10:0];
                ltteb_pkg::REG_RANGE_MIN:     cfg_reg.range_min_mm  <= cfg_data[15:0];
                ltteb_pkg::REG_RANGE_MAX:     cfg_reg.range_max_mm  <= cfg_data[15:0];
                ltteb_pkg::REG_NEAR_STOP:     cfg_reg.near_stop_mm  <= cfg_data[15:0];
                ltteb_pkg::REG_JUMP_LIMIT:    cfg_reg.jump_limit_mm <= cfg_data[15:0];
                ltteb_pkg::REG_MAX_SPEED:     cfg_reg.max_speed_mm_per_s <= cfg_data;
                ltteb_pkg::REG_TTC_THRESHOLD:
                    cfg_reg.ttc_threshold_us <= 30'(cfg_data) * 30'(ltteb_pkg::US_PER_MS);
                default: ;
            endcase
        end
    end

    ltteb_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .in_item       (in_item),
        .forward_index (cfg_reg.forward_index),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .q_pop         (q_pop)
    );

    ltteb_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

endmodule

`default_nettype wire
